>>> sv/trm_pkg.sv
// types and constants for the register machine execute block
// no dependencies
`timescale 1ns / 1ps
package trm_pkg;

    typedef struct packed {
        logic        op;
        logic [31:0] instruction;
        logic signed [31:0] read_data;
    } t_in;

    typedef struct packed {
        logic signed [31:0] next_pc;
        logic [1:0]         mem_kind;
        logic signed [31:0] mem_addr;
        logic signed [31:0] mem_data;
        logic [3:0]         flags;
        logic               waiting_read;
        logic               bad_item;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_OUT
    } t_state;

    localparam logic [1:0] MK_NONE  = 2'd0;
    localparam logic [1:0] MK_READ  = 2'd1;
    localparam logic [1:0] MK_WRITE = 2'd2;

    localparam logic [15:0] H_ADD  = 16'h0100;
    localparam logic [15:0] H_SUB  = 16'h0101;
    localparam logic [15:0] H_MUL  = 16'h0102;
    localparam logic [15:0] H_DIV  = 16'h0103;
    localparam logic [15:0] H_MOD  = 16'h0104;
    localparam logic [15:0] H_AND  = 16'h0110;
    localparam logic [15:0] H_OR   = 16'h0111;
    localparam logic [15:0] H_NOT  = 16'h0112;
    localparam logic [15:0] H_XOR  = 16'h0113;
    localparam logic [15:0] H_CMP  = 16'h0120;
    localparam logic [15:0] H_LDR  = 16'h0000;
    localparam logic [15:0] H_STR  = 16'h0001;
    localparam logic [15:0] H_PUSH = 16'h0010;
    localparam logic [15:0] H_POP  = 16'h0011;
    localparam logic [15:0] H_IFX  = 16'h0200;
    localparam logic [3:0]  TOP_SET = 4'h1;
    localparam logic [31:0] SP_RESET = 32'h0FFF_FFFF;

endpackage

>>> sv/toy_register_machine_execute.sv
// register machine execute block: decode, register file, shared divider
// depends on trm_pkg
//
// usage: one input transfer per item (instruction word or read response),
// one output transfer per item with next pc, memory request and status.
// input stall is high while an item is in progress or a result waits.
// most items are executed straight into the output register, so their result
// is presented in the cycle after acceptance.
// DIV and MOD with a nonzero divisor run a one-bit-per-cycle restoring
// divider (S_DIV) and then a sign fix step (S_FIX) before the result is
// presented; no new item is taken until that result has been transferred.
// reset: r1 = 0x0FFFFFFF, all other registers, flags and pending read
// state zero; no transfer pending on either channel.
// a stalled output holds its result; the next item is taken once the
// result has been transferred.
`timescale 1ns / 1ps
module toy_register_machine_execute
    import trm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_state r_state, n_state;
    logic [31:0] r_regs [16];
    logic [3:0]  r_flags;
    logic        r_pend, r_pop;
    logic [3:0]  r_pdest;
    t_out        r_out;
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_neg_q, r_neg_r, r_mod;
    logic [3:0]  r_dst;

    logic        acc;
    logic [31:0] w, x, y, sp_inc, sp_dec;
    logic [15:0] h;
    logic [3:0]  d, a, b;
    logic [32:0] trial;
    logic [31:0] rem_sh, ax, ay, dres;
    logic signed [31:0] sx, sy;

    assign acc   = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    assign w = i_data.instruction;
    assign h = w[31:16];
    assign d = w[11:8];
    assign a = w[7:4];
    assign b = w[3:0];
    assign x = r_regs[a];
    assign y = r_regs[b];
    assign sx = x;
    assign sy = y;
    assign sp_inc = r_regs[1] + 32'd4;
    assign sp_dec = r_regs[1] - 32'd4;
    assign ax = x[31] ? 32'd0 - x : x;
    assign ay = y[31] ? 32'd0 - y : y;

    // one restoring division step
    assign rem_sh = {r_rem[30:0], r_quo[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_dvs};
    assign dres = r_mod ? (r_neg_r ? 32'd0 - r_rem : r_rem)
                        : (r_neg_q ? 32'd0 - r_quo : r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (!i_data.op && !r_pend && (h == H_DIV || h == H_MOD) && y != 32'd0)
                        n_state = S_DIV;
                    else
                        n_state = S_OUT;
                end
            end
            S_DIV: if (r_cnt == 6'd31) n_state = S_FIX;
            S_FIX: n_state = S_OUT;
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_regs[i] <= (i == 1) ? SP_RESET : 32'd0;
            r_flags <= 4'd0;
            r_pend  <= 1'b0;
            r_pop   <= 1'b0;
            r_pdest <= 4'd0;
        end else begin
            case (r_state)
                S_IDLE: if (acc) begin
                    r_out.mem_kind <= MK_NONE;
                    r_out.mem_addr <= 32'd0;
                    r_out.mem_data <= 32'd0;
                    r_out.bad_item <= 1'b0;
                    r_out.waiting_read <= r_pend;
                    r_out.flags <= r_flags;
                    r_out.next_pc <= r_regs[0];
                    if (i_data.op) begin
                        if (!r_pend) begin
                            r_out.bad_item <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                            r_out.waiting_read <= 1'b0;
                            if (r_pdest == 4'd0) begin
                                r_regs[0] <= i_data.read_data + 32'd4;
                                r_out.next_pc <= i_data.read_data + 32'd4;
                            end else if (r_pdest == 4'd1 && r_pop) begin
                                r_regs[1] <= i_data.read_data - 32'd4;
                            end else begin
                                r_regs[r_pdest] <= i_data.read_data;
                            end
                        end
                    end else if (r_pend) begin
                        r_out.bad_item <= 1'b1;
                    end else begin
                        logic [31:0] res;
                        logic        wr, bad, skip;
                        logic [3:0]  dst;
                        res = 32'd0; wr = 1'b0; bad = 1'b0; skip = 1'b0; dst = d;
                        if (w[31:28] == TOP_SET) begin
                            res = {8'd0, w[23:0]}; wr = 1'b1; dst = w[27:24];
                        end else begin
                            case (h)
                                H_ADD: begin res = x + y; wr = 1'b1; end
                                H_SUB: begin res = x - y; wr = 1'b1; end
                                H_MUL: begin res = x * y; wr = 1'b1; end
                                H_DIV: begin res = 32'hFFFF_FFFF; wr = (y == 32'd0); end
                                H_MOD: begin res = x; wr = (y == 32'd0); end
                                H_AND: begin res = x & y; wr = 1'b1; end
                                H_OR:  begin res = x | y; wr = 1'b1; end
                                H_NOT: begin res = ~x; wr = 1'b1; end
                                H_XOR: begin res = x ^ y; wr = 1'b1; end
                                H_CMP: begin
                                    r_flags <= {sx < sy, sx > sy, sx != sy, sx == sy};
                                    r_out.flags <= {sx < sy, sx > sy, sx != sy, sx == sy};
                                end
                                H_LDR: begin
                                    r_out.mem_kind <= MK_READ;
                                    r_out.mem_addr <= y;
                                    r_pend <= 1'b1; r_pdest <= a; r_pop <= 1'b0;
                                    r_out.waiting_read <= 1'b1;
                                end
                                H_STR: begin
                                    r_out.mem_kind <= MK_WRITE;
                                    r_out.mem_addr <= y;
                                    r_out.mem_data <= x;
                                end
                                H_PUSH: begin
                                    r_out.mem_kind <= MK_WRITE;
                                    r_out.mem_addr <= sp_inc;
                                    r_out.mem_data <= (b == 4'd1) ? sp_inc : y;
                                    res = sp_inc; wr = 1'b1; dst = 4'd1;
                                end
                                H_POP: begin
                                    r_out.mem_kind <= MK_READ;
                                    r_out.mem_addr <= r_regs[1];
                                    res = sp_dec; wr = 1'b1; dst = 4'd1;
                                    r_pend <= 1'b1; r_pdest <= b; r_pop <= 1'b1;
                                    r_out.waiting_read <= 1'b1;
                                end
                                H_IFX: skip = ((w[3:0] & r_flags) == 4'd0);
                                default: bad = 1'b1;
                            endcase
                        end
                        r_out.bad_item <= bad;
                        if (wr && dst != 4'd0) r_regs[dst] <= res;
                        if (wr && dst == 4'd0) begin
                            r_regs[0] <= res + 32'd4;
                            r_out.next_pc <= res + 32'd4;
                        end else begin
                            r_regs[0] <= r_regs[0] + (skip ? 32'd8 : 32'd4);
                            r_out.next_pc <= r_regs[0] + (skip ? 32'd8 : 32'd4);
                        end
                        r_dst <= d;
                        r_mod <= (h == H_MOD);
                        r_neg_q <= x[31] ^ y[31];
                        r_neg_r <= x[31];
                        r_quo <= ax;
                        r_dvs <= ay;
                        r_rem <= 32'd0;
                        r_cnt <= 6'd0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (!trial[32]) begin
                        r_rem <= trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                end
                S_FIX: begin
                    // pc already advanced; a write to r0 lands as value plus 4
                    if (r_dst == 4'd0) begin
                        r_regs[0] <= dres + 32'd4;
                        r_out.next_pc <= dres + 32'd4;
                    end else begin
                        r_regs[r_dst] <= dres;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> sv/trm_checker.sv
// port-level checker for the register machine execute block
// depends on trm_pkg and toy_register_machine_execute
`timescale 1ns / 1ps
module trm_checker
    import trm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // result held while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // no input transfer while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result waits");

    // an accepted item raises the input stall
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted item did not start");

    // read requests always flag a pending read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.mem_kind == MK_READ |-> o_data.waiting_read)
        else $error("read request without pending flag");

endmodule

bind toy_register_machine_execute trm_checker u_trm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
